// ----- sv/fss_pkg.sv -----
// Shared types and constants for the fixed string sorter.
// Depends on nothing; every other file of the block but fss_ram imports it.
package fss_pkg;

  localparam int CHUNK_W          = 64;
  localparam int DEF_MAX_STRINGS  = 8;
  localparam int DEF_STRING_BYTES = 20;

  typedef logic [CHUNK_W-1:0] chunk_t;

  typedef struct packed {
    logic clear;
    logic step;
  } cmp_ctrl_t;

  typedef struct packed {
    logic decided;
    logic greater;
  } cmp_stat_t;

endpackage

// ----- sv/fss_if.sv -----
// Valid/ready channel interfaces for the sorter's input and result words.
// Depends on fss_pkg for the chunk type.
interface fss_in_if;
  import fss_pkg::*;

  logic   valid;
  logic   ready;
  chunk_t text_chunk;
  logic   string_end;
  logic   set_end;

  modport source (output valid, output text_chunk, output string_end, output set_end,
                  input ready);
  modport sink (input valid, input text_chunk, input string_end, input set_end,
                output ready);
endinterface

interface fss_out_if;
  import fss_pkg::*;

  logic   valid;
  logic   ready;
  chunk_t sorted_chunk;
  logic   string_done;
  logic   last_result;
  logic   overflow;

  modport source (output valid, output sorted_chunk, output string_done,
                  output last_result, output overflow, input ready);
  modport sink (input valid, input sorted_chunk, input string_done,
                input last_result, input overflow, output ready);
endinterface

// ----- sv/fss_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module fss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/fss_clean.sv -----
// Chunk cleaner: zeroes every byte after the first NUL and past the string limit.
// Depends on fss_pkg for the chunk type.
module fss_clean #(
  parameter int STRING_BYTES = 20,
  parameter int IDX_W        = 2
) (
  input  fss_pkg::chunk_t   chunk_in,
  input  logic [IDX_W-1:0]  chunk_idx,
  input  logic              ended_in,
  output fss_pkg::chunk_t   chunk_out,
  output logic              ended_out
);
  import fss_pkg::*;

  always_comb begin
    logic       ended;
    logic [7:0] bval;
    int         pos;
    ended     = ended_in;
    chunk_out = '0;
    for (int b = 0; b < 8; b++) begin
      pos  = int'(chunk_idx) * 8 + b;
      bval = chunk_in[CHUNK_W-1-8*b -: 8];
      if (ended || pos >= STRING_BYTES) begin
        bval = 8'd0;
      end
      if (bval == 8'd0) begin
        ended = 1'b1;
      end
      chunk_out[CHUNK_W-1-8*b -: 8] = bval;
    end
    ended_out = ended;
  end

endmodule

// ----- sv/fss_cmp.sv -----
// Shared chunk comparator: walks two strings chunk by chunk and keeps the verdict.
// Depends on fss_pkg for the chunk and control types.
module fss_cmp (
  input  logic                clk,
  input  logic                rst_n,
  input  fss_pkg::cmp_ctrl_t  ctrl,
  input  fss_pkg::chunk_t     a,
  input  fss_pkg::chunk_t     b,
  output fss_pkg::cmp_stat_t  stat
);
  import fss_pkg::*;

  logic decided_r, decided_nxt;
  logic greater_r, greater_nxt;

  always_comb begin
    decided_nxt = decided_r;
    greater_nxt = greater_r;
    if (ctrl.clear) begin
      decided_nxt = 1'b0;
      greater_nxt = 1'b0;
    end else if (ctrl.step && !decided_r && (a != b)) begin
      decided_nxt = 1'b1;
      greater_nxt = (a > b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decided_r <= 1'b0;
      greater_r <= 1'b0;
    end else begin
      decided_r <= decided_nxt;
      greater_r <= greater_nxt;
    end
  end

  assign stat.decided = decided_r;
  assign stat.greater = greater_r;

endmodule

// ----- sv/fixed_string_sorter.sv -----
// Fixed string sorter top level: loads up to MAX_STRINGS strings of up to STRING_BYTES
// bytes, each as CHUNKS = ceil(STRING_BYTES/8) words, and returns them in strcmp order.
// Every string is cleaned as it arrives and stored in one single-write, single-read RAM
// of MAX_STRINGS*CHUNKS words. Loading takes one input word per cycle, save while the
// chunks a short string leaves out are filled with zeros. The set's last word starts an
// exchange sort on the RAM and one shared 64-bit comparator: per outer position the
// string is loaded into a buffer and written back, per inner pair the other string is
// read and compared and, on a swap, the buffered one goes to the other slot. Results
// leave one at a time via the registered RAM read, the next waiting for the last to be
// taken. The input is not ready from the set's last word until its last result word is
// taken. Strings past capacity are dropped and flagged on every result word of that set.
// Depends on fss_pkg, fss_if, fss_ram, fss_clean and fss_cmp.
module fixed_string_sorter #(
  parameter int MAX_STRINGS  = fss_pkg::DEF_MAX_STRINGS,
  parameter int STRING_BYTES = fss_pkg::DEF_STRING_BYTES
) (
  input logic      clk,
  input logic      rst_n,
  fss_in_if.sink   in_ch,
  fss_out_if.source out_ch
);
  import fss_pkg::*;

  localparam int CHUNKS = (STRING_BYTES + 7) / 8;
  localparam int DEPTH  = MAX_STRINGS * CHUNKS;
  localparam int AW     = $clog2(DEPTH);
  localparam int SW     = $clog2(MAX_STRINGS + 1);
  localparam int CW     = $clog2(CHUNKS + 1);
  localparam int CIW    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_FILL = 4'd1;
  localparam logic [3:0] ST_SORT = 4'd2;
  localparam logic [3:0] ST_LDA  = 4'd3;
  localparam logic [3:0] ST_LDB  = 4'd4;
  localparam logic [3:0] ST_DEC  = 4'd5;
  localparam logic [3:0] ST_SWAP = 4'd6;
  localparam logic [3:0] ST_WBA  = 4'd7;
  localparam logic [3:0] ST_ORD  = 4'd8;
  localparam logic [3:0] ST_OLD  = 4'd9;
  localparam logic [3:0] ST_OWT  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [SW-1:0] count_r, count_nxt;
  logic [CW-1:0] cidx_r, cidx_nxt;
  logic          ended_r, ended_nxt;
  logic          ovf_r, ovf_nxt;
  logic          setend_r, setend_nxt;
  logic [SW-1:0] i_r, i_nxt;
  logic [SW-1:0] j_r, j_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic          rv_r, rv_nxt;
  logic [CW-1:0] rc_r, rc_nxt;
  chunk_t        a_buf_r [CHUNKS];
  chunk_t        a_buf_nxt [CHUNKS];
  chunk_t        b_buf_r [CHUNKS];
  chunk_t        b_buf_nxt [CHUNKS];
  logic          ovalid_r, ovalid_nxt;
  chunk_t        odata_r, odata_nxt;
  logic          odone_r, odone_nxt;
  logic          olast_r, olast_nxt;
  logic          oovf_r, oovf_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  chunk_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  chunk_t        ram_rdata;

  chunk_t        clean_chunk;
  logic          clean_ended;
  logic          clean_ended_in;
  logic [CW-1:0] cinc;
  logic [CW-1:0] buf_idx;
  chunk_t        a_sel;
  cmp_ctrl_t     cmp_ctrl;
  cmp_stat_t     cmp_stat;

  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] idx,
                                               input logic [CW-1:0] c);
    slot_addr = AW'(idx) * AW'(CHUNKS) + AW'(c);
  endfunction

  fss_ram #(
    .WIDTH (CHUNK_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign clean_ended_in = (cidx_r == '0) ? 1'b0 : ended_r;

  fss_clean #(
    .STRING_BYTES (STRING_BYTES),
    .IDX_W        (CW)
  ) u_clean (
    .chunk_in  (in_ch.text_chunk),
    .chunk_idx (cidx_r),
    .ended_in  (clean_ended_in),
    .chunk_out (clean_chunk),
    .ended_out (clean_ended)
  );

  assign buf_idx = (state_r == ST_LDB) ? rc_r : c_r;
  assign a_sel   = a_buf_r[buf_idx[CIW-1:0]];

  fss_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (cmp_ctrl),
    .a     (a_sel),
    .b     (ram_rdata),
    .stat  (cmp_stat)
  );

  assign cinc = (cidx_r < CW'(CHUNKS)) ? cidx_r + CW'(1) : cidx_r;

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    cidx_nxt   = cidx_r;
    ended_nxt  = ended_r;
    ovf_nxt    = ovf_r;
    setend_nxt = setend_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    c_nxt      = c_r;
    rv_nxt     = 1'b0;
    rc_nxt     = c_r;
    a_buf_nxt  = a_buf_r;
    b_buf_nxt  = b_buf_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    odone_nxt  = odone_r;
    olast_nxt  = olast_r;
    oovf_nxt   = oovf_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    cmp_ctrl   = '0;

    case (state_r)
      ST_LOAD: begin
        if (in_ch.valid) begin
          if ((count_r < SW'(MAX_STRINGS)) && (cidx_r < CW'(CHUNKS))) begin
            ram_we    = 1'b1;
            ram_waddr = slot_addr(count_r, cidx_r);
            ram_wdata = clean_chunk;
            ended_nxt = clean_ended;
          end
          cidx_nxt = cinc;
          if (in_ch.string_end || in_ch.set_end) begin
            cidx_nxt   = '0;
            setend_nxt = in_ch.set_end;
            if (count_r < SW'(MAX_STRINGS)) begin
              if (cinc < CW'(CHUNKS)) begin
                c_nxt     = cinc;
                state_nxt = ST_FILL;
              end else begin
                count_nxt = count_r + SW'(1);
                if (in_ch.set_end) begin
                  state_nxt = ST_SORT;
                end
              end
            end else begin
              ovf_nxt = 1'b1;
              if (in_ch.set_end) begin
                state_nxt = ST_SORT;
              end
            end
          end
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr(count_r, c_r);
        ram_wdata = '0;
        c_nxt     = c_r + CW'(1);
        if (c_r == CW'(CHUNKS - 1)) begin
          count_nxt = count_r + SW'(1);
          state_nxt = setend_r ? ST_SORT : ST_LOAD;
        end
      end
      ST_SORT: begin
        i_nxt = '0;
        j_nxt = SW'(1);
        c_nxt = '0;
        state_nxt = (count_r < SW'(2)) ? ST_ORD : ST_LDA;
      end
      ST_LDA: begin
        if (c_r < CW'(CHUNKS)) begin
          ram_re    = 1'b1;
          ram_raddr = slot_addr(i_r, c_r);
          c_nxt     = c_r + CW'(1);
          rv_nxt    = 1'b1;
        end
        if (rv_r) begin
          a_buf_nxt[rc_r[CIW-1:0]] = ram_rdata;
          if (rc_r == CW'(CHUNKS - 1)) begin
            c_nxt          = '0;
            cmp_ctrl.clear = 1'b1;
            state_nxt      = ST_LDB;
          end
        end
      end
      ST_LDB: begin
        if (c_r < CW'(CHUNKS)) begin
          ram_re    = 1'b1;
          ram_raddr = slot_addr(j_r, c_r);
          c_nxt     = c_r + CW'(1);
          rv_nxt    = 1'b1;
        end
        if (rv_r) begin
          b_buf_nxt[rc_r[CIW-1:0]] = ram_rdata;
          cmp_ctrl.step = 1'b1;
          if (rc_r == CW'(CHUNKS - 1)) begin
            c_nxt     = '0;
            state_nxt = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        c_nxt = '0;
        if (cmp_stat.greater) begin
          state_nxt = ST_SWAP;
        end else if (j_r == count_r - SW'(1)) begin
          state_nxt = ST_WBA;
        end else begin
          j_nxt          = j_r + SW'(1);
          cmp_ctrl.clear = 1'b1;
          state_nxt      = ST_LDB;
        end
      end
      ST_SWAP: begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr(j_r, c_r);
        ram_wdata = a_sel;
        c_nxt     = c_r + CW'(1);
        if (c_r == CW'(CHUNKS - 1)) begin
          a_buf_nxt = b_buf_r;
          c_nxt     = '0;
          if (j_r == count_r - SW'(1)) begin
            state_nxt = ST_WBA;
          end else begin
            j_nxt          = j_r + SW'(1);
            cmp_ctrl.clear = 1'b1;
            state_nxt      = ST_LDB;
          end
        end
      end
      ST_WBA: begin
        ram_we    = 1'b1;
        ram_waddr = slot_addr(i_r, c_r);
        ram_wdata = a_sel;
        c_nxt     = c_r + CW'(1);
        if (c_r == CW'(CHUNKS - 1)) begin
          c_nxt = '0;
          if (i_r == count_r - SW'(2)) begin
            i_nxt     = '0;
            state_nxt = ST_ORD;
          end else begin
            i_nxt     = i_r + SW'(1);
            j_nxt     = i_r + SW'(2);
            state_nxt = ST_LDA;
          end
        end
      end
      ST_ORD: begin
        ram_re    = 1'b1;
        ram_raddr = slot_addr(i_r, c_r);
        state_nxt = ST_OLD;
      end
      ST_OLD: begin
        ovalid_nxt = 1'b1;
        odata_nxt  = ram_rdata;
        odone_nxt  = (c_r == CW'(CHUNKS - 1));
        olast_nxt  = (c_r == CW'(CHUNKS - 1)) && (i_r == count_r - SW'(1));
        oovf_nxt   = ovf_r;
        state_nxt  = ST_OWT;
      end
      ST_OWT: begin
        if (out_ch.ready) begin
          ovalid_nxt = 1'b0;
          if (olast_r) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            cidx_nxt  = '0;
            state_nxt = ST_LOAD;
          end else if (odone_r) begin
            i_nxt     = i_r + SW'(1);
            c_nxt     = '0;
            state_nxt = ST_ORD;
          end else begin
            c_nxt     = c_r + CW'(1);
            state_nxt = ST_ORD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      count_r  <= '0;
      cidx_r   <= '0;
      ended_r  <= 1'b0;
      ovf_r    <= 1'b0;
      setend_r <= 1'b0;
      rv_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      cidx_r   <= cidx_nxt;
      ended_r  <= ended_nxt;
      ovf_r    <= ovf_nxt;
      setend_r <= setend_nxt;
      rv_r     <= rv_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    c_r     <= c_nxt;
    rc_r    <= rc_nxt;
    a_buf_r <= a_buf_nxt;
    b_buf_r <= b_buf_nxt;
    odata_r <= odata_nxt;
    odone_r <= odone_nxt;
    olast_r <= olast_nxt;
    oovf_r  <= oovf_nxt;
  end

  assign in_ch.ready         = (state_r == ST_LOAD);
  assign out_ch.valid        = ovalid_r;
  assign out_ch.sorted_chunk = odata_r;
  assign out_ch.string_done  = odone_r;
  assign out_ch.last_result  = olast_r;
  assign out_ch.overflow     = oovf_r;

`ifndef SYNTHESIS
  a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("Input is ready while a result word is pending.");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SW'(MAX_STRINGS))
    else $error("String count exceeds capacity.");

  a_last_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last_result) |-> out_ch.string_done)
    else $error("Last result word does not end a string.");

  a_swap_decided: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWAP) |-> cmp_stat.decided)
    else $error("Swap started without a decided comparison.");
`endif

endmodule

// ----- tb/tb_fixed_string_sorter.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fixed_string_sorter: directed and random string sets go in,
// and every sorted word that comes out is checked against a sorting model kept here.
// Depends on fss_pkg, fss_if and the sorter RTL.
module tb_fixed_string_sorter;
  import fss_pkg::*;

  localparam int MAX_STR      = DEF_MAX_STRINGS;
  localparam int STR_BYTES    = DEF_STRING_BYTES;
  localparam int CHUNKS       = (STR_BYTES + 7) / 8;
  localparam int KEY_W        = CHUNKS * CHUNK_W;
  localparam int SRC_W        = 5 * CHUNK_W;
  localparam int RAND_WORDS   = 80;
  localparam int TAIL_WORDS   = 25;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 200000;

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [SRC_W-1:0] src_t;

  typedef struct {
    chunk_t text;
    logic   str_end;
    logic   set_end;
  } in_word_t;

  typedef struct {
    chunk_t chunk;
    logic   done;
    logic   last;
    logic   ovf;
  } out_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  fss_in_if  in_ch ();
  fss_out_if out_ch ();

  fixed_string_sorter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_t        held_keys [MAX_STR];
  int unsigned held_cnt = 0;
  int unsigned chunk_pos = 0;
  logic        dropped = 1'b0;

  in_word_t  words_q [$];
  out_word_t sorted_q [$];

  int   errors = 0;
  int   cyc = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  logic in_taken = 1'b0;
  logic may_stall = 1'b0;

  always #4 clk = ~clk;

  function automatic key_t clean_key(key_t raw);
    key_t       k;
    logic       ended;
    logic [7:0] b;
    k = '0;
    ended = 1'b0;
    for (int i = 0; i < CHUNKS * 8; i++) begin
      b = raw[KEY_W-1-8*i -: 8];
      if (ended || i >= STR_BYTES) b = 8'h00;
      if (b == 8'h00) ended = 1'b1;
      k[KEY_W-1-8*i -: 8] = b;
    end
    return k;
  endfunction

  function automatic void absorb_word(in_word_t w);
    key_t      t;
    out_word_t r;
    if (held_cnt < MAX_STR) begin
      if (chunk_pos == 0) held_keys[held_cnt] = '0;
      if (chunk_pos < CHUNKS)
        held_keys[held_cnt][KEY_W-1-CHUNK_W*chunk_pos -: CHUNK_W] = w.text;
    end
    if (chunk_pos < CHUNKS) chunk_pos++;
    if (w.str_end || w.set_end) begin
      if (held_cnt < MAX_STR) begin
        held_keys[held_cnt] = clean_key(held_keys[held_cnt]);
        held_cnt++;
      end else begin
        dropped = 1'b1;
      end
      chunk_pos = 0;
    end
    if (w.set_end) begin
      for (int i = 0; i + 1 < held_cnt; i++) begin
        for (int j = i + 1; j < held_cnt; j++) begin
          if (held_keys[i] > held_keys[j]) begin
            t = held_keys[i];
            held_keys[i] = held_keys[j];
            held_keys[j] = t;
          end
        end
      end
      for (int s = 0; s < held_cnt; s++) begin
        for (int c = 0; c < CHUNKS; c++) begin
          r.chunk = held_keys[s][KEY_W-1-CHUNK_W*c -: CHUNK_W];
          r.done = (c == CHUNKS - 1);
          r.last = r.done && (s == held_cnt - 1);
          r.ovf = dropped;
          sorted_q.push_back(r);
        end
      end
      held_cnt = 0;
      chunk_pos = 0;
      dropped = 1'b0;
    end
  endfunction

  function automatic void queue_string(src_t text, int n_chunks, bit closes_set, bit with_end);
    in_word_t w;
    for (int c = 0; c < n_chunks; c++) begin
      w.text = text[SRC_W-1-CHUNK_W*c -: CHUNK_W];
      w.str_end = (c == n_chunks - 1) && (!closes_set || with_end);
      w.set_end = (c == n_chunks - 1) && closes_set;
      words_q.push_back(w);
    end
  endfunction

  function automatic src_t make_text(int style, src_t prev);
    src_t t;
    int   len;
    int   keep;
    len = $urandom_range(0, 24);
    keep = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 20) : 0;
    for (int i = 0; i < SRC_W / 8; i++) begin
      if (i < keep) t[SRC_W-1-8*i -: 8] = prev[SRC_W-1-8*i -: 8];
      else if (style == 2) t[SRC_W-1-8*i -: 8] = 8'($urandom);
      else if (i < len && style == 0) t[SRC_W-1-8*i -: 8] = 8'h61 + 8'($urandom_range(0, 2));
      else if (i < len) t[SRC_W-1-8*i -: 8] = 8'($urandom_range(1, 255));
      else if (i == len) t[SRC_W-1-8*i -: 8] = 8'h00;
      else t[SRC_W-1-8*i -: 8] = 8'($urandom);
    end
    return t;
  endfunction

  initial begin
    int   rand_count;
    int   n_str;
    int   n_chunks;
    int   style;
    int   pick;
    src_t text;
    src_t prev;

    in_ch.valid = 1'b0;
    in_ch.text_chunk = '0;
    in_ch.string_end = 1'b0;
    in_ch.set_end = 1'b0;
    out_ch.ready = 1'b0;

    queue_string({5{64'hFFFF_FFFF_FFFF_FFFF}}, CHUNKS, 0, 1);
    queue_string('0, 1, 0, 1);
    queue_string({64'h6162_6300_1122_3344, 256'h0}, 1, 0, 1);
    queue_string({64'h6162_6300_FFEE_DDCC, 256'h0}, 1, 0, 1);
    queue_string({64'h4142_4344_4546_4748, 64'h494A_4B4C_4D4E_4F50, 64'h5152_5354_5556_5758,
                  64'h1111_1111_1111_1111, 64'h2222_2222_2222_2222}, 5, 0, 1);
    queue_string({64'h6162_6364_6566_6768, 64'h6900_8081_8283_8485, 192'h0}, 2, 1, 0);
    for (int k = 0; k < MAX_STR + 1; k++)
      queue_string({8'h7A - 8'(k), 8'h00, 48'hFFFF_FFFF_FFFF, 256'h0}, 1, k == MAX_STR, 1);
    queue_string({64'h8000_0000_0000_0001, 256'h0}, 1, 1, 0);

    rand_count = 0;
    while (rand_count < RAND_WORDS) begin
      n_str = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_STR + 1, MAX_STR + 3)
                                          : $urandom_range(1, MAX_STR);
      style = $urandom_range(0, 2);
      prev = '0;
      for (int s = 0; s < n_str; s++) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) n_chunks = CHUNKS;
        else if (pick < 17) n_chunks = $urandom_range(1, CHUNKS - 1);
        else n_chunks = $urandom_range(CHUNKS + 1, CHUNKS + 2);
        text = make_text(style, prev);
        prev = text;
        queue_string(text, n_chunks, s == n_str - 1, $urandom_range(0, 1));
        rand_count += n_chunks;
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (words_q.size() != 0 || in_ch.valid || sorted_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("** fixed_string_sorter: PASSED **");
    end else begin
      $display("** fixed_string_sorter: FAILED **");
    end
    $finish;
  end

  always @(negedge clk) begin
    in_word_t w;
    if (rst_n) begin
      if (!in_ch.valid || in_taken) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (words_q.size() != 0) begin
          w = words_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.text_chunk <= w.text;
          in_ch.string_end <= w.str_end;
          in_ch.set_end <= w.set_end;
          if (may_stall && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 7);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap = out_gap - 1;
      out_ch.ready <= 1'b0;
    end else if (may_stall && $urandom_range(0, 3) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    in_word_t  w;
    out_word_t got;
    out_word_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      w.text = in_ch.text_chunk;
      w.str_end = in_ch.string_end;
      w.set_end = in_ch.set_end;
      absorb_word(w);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.chunk = out_ch.sorted_chunk;
      got.done = out_ch.string_done;
      got.last = out_ch.last_result;
      got.ovf = out_ch.overflow;
      if (sorted_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word %h done=%b last=%b overflow=%b", $time,
                 got.chunk, got.done, got.last, got.ovf);
      end else begin
        want = sorted_q.pop_front();
        if (got.chunk !== want.chunk || got.done !== want.done ||
            got.last !== want.last || got.ovf !== want.ovf) begin
          errors++;
          $display("%0t: expected %h d=%b l=%b o=%b, got %h d=%b l=%b o=%b",
                   $time, want.chunk, want.done, want.last, want.ovf,
                   got.chunk, got.done, got.last, got.ovf);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    may_stall <= (words_q.size() > TAIL_WORDS) && (((cyc >> 6) & 1) == 1);
    if (cyc >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d result words outstanding", $time, sorted_q.size());
      $display("** fixed_string_sorter: FAILED **");
      $finish;
    end
  end

endmodule

// ----- sim.f -----
sv/fss_pkg.sv
sv/fss_if.sv
sv/fss_ram.sv
sv/fss_clean.sv
sv/fss_cmp.sv
sv/fixed_string_sorter.sv
tb/tb_fixed_string_sorter.sv
